/* rtl/sjk_pkg.sv */
`timescale 1ns / 1ps
package sjk_pkg;

  localparam logic [15:0] CP_REPLACEMENT = 16'h25A1;
  localparam logic [15:0] CP_HALF_KANA   = 16'hFF61;
  localparam logic [15:0] CP_HIRAGANA    = 16'h3041;
  localparam logic [15:0] CP_KATAKANA    = 16'h30A1;

  localparam logic [7:0] HALF_KANA_LO = 8'hA1;
  localparam logic [7:0] HALF_KANA_HI = 8'hDF;
  localparam logic [7:0] HIRA_LEAD    = 8'h82;
  localparam logic [7:0] HIRA_LO      = 8'h9F;
  localparam logic [7:0] HIRA_HI      = 8'hF1;
  localparam logic [7:0] KATA_LEAD    = 8'h83;
  localparam logic [7:0] KATA_LO      = 8'h40;
  localparam logic [7:0] KATA_HI      = 8'h96;
  localparam logic [7:0] KATA_GAP     = 8'h7F;
  localparam logic [7:0] HIGH_BIT     = 8'h80;

  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  typedef enum logic [1:0] {
    JOB_SINGLE,
    JOB_TRIPLE,
    JOB_TRIPLE_NUL
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] cp;
  } job_t;

endpackage

/* rtl/sjk_in_if.sv */
`timescale 1ns / 1ps
interface sjk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

/* rtl/sjk_out_if.sv */
`timescale 1ns / 1ps
interface sjk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, output out_byte, output run_end, input ready);
  modport sink (input valid, input out_byte, input run_end, output ready);
endinterface

/* rtl/sjk_front.sv */
`timescale 1ns / 1ps
module sjk_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          push_valid,
  input  logic          push_ready,
  output sjk_pkg::job_t push_job
);

  logic       lead_pending;
  logic       lead_pending_next;
  logic [7:0] lead_value;
  logic [7:0] lead_value_next;
  logic       accept;
  logic       is_lead;
  logic [15:0] pair_cp;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pair_cp = sjk_pkg::CP_REPLACEMENT;
    if (lead_value == sjk_pkg::HIRA_LEAD && in_byte >= sjk_pkg::HIRA_LO &&
        in_byte <= sjk_pkg::HIRA_HI) begin
      pair_cp = sjk_pkg::CP_HIRAGANA + {8'h00, in_byte - sjk_pkg::HIRA_LO};
    end else if (lead_value == sjk_pkg::KATA_LEAD && in_byte >= sjk_pkg::KATA_LO &&
                 in_byte <= sjk_pkg::KATA_HI) begin
      if (in_byte == sjk_pkg::KATA_GAP) begin
        pair_cp = sjk_pkg::CP_REPLACEMENT;
      end else if (in_byte >= sjk_pkg::HIGH_BIT) begin
        pair_cp = sjk_pkg::CP_KATAKANA + {8'h00, in_byte - sjk_pkg::KATA_LO} - 16'd1;
      end else begin
        pair_cp = sjk_pkg::CP_KATAKANA + {8'h00, in_byte - sjk_pkg::KATA_LO};
      end
    end
  end

  always_comb begin
    is_lead       = 1'b0;
    push_job.kind = sjk_pkg::JOB_SINGLE;
    push_job.cp   = {8'h00, in_byte};
    priority if (lead_pending) begin
      if (in_byte == sjk_pkg::NUL_BYTE) begin
        push_job.kind = sjk_pkg::JOB_TRIPLE_NUL;
        push_job.cp   = sjk_pkg::CP_REPLACEMENT;
      end else begin
        push_job.kind = sjk_pkg::JOB_TRIPLE;
        push_job.cp   = pair_cp;
      end
    end else if (in_byte < sjk_pkg::HIGH_BIT) begin
      push_job.kind = sjk_pkg::JOB_SINGLE;
    end else if (in_byte >= sjk_pkg::HALF_KANA_LO && in_byte <= sjk_pkg::HALF_KANA_HI) begin
      push_job.kind = sjk_pkg::JOB_TRIPLE;
      push_job.cp   = sjk_pkg::CP_HALF_KANA + {8'h00, in_byte - sjk_pkg::HALF_KANA_LO};
    end else begin
      is_lead = 1'b1;
    end
  end

  assign push_valid = in_valid && !is_lead;

  always_comb begin
    lead_pending_next = lead_pending;
    lead_value_next   = lead_value;
    if (accept) begin
      lead_pending_next = is_lead;
      lead_value_next   = is_lead ? in_byte : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      lead_value   <= 8'h00;
    end else begin
      lead_pending <= lead_pending_next;
      lead_value   <= lead_value_next;
    end
  end

  a_lead_cleared: assert property (@(posedge clk) disable iff (rst)
    !lead_pending |-> lead_value == 8'h00)
    else $error("lead value kept without a pending lead");

endmodule

/* rtl/sjk_queue.sv */
`timescale 1ns / 1ps
module sjk_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  sjk_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sjk_pkg::job_t pop_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sjk_pkg::job_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = count < CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/sjk_back.sv */
`timescale 1ns / 1ps
module sjk_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  sjk_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          run_end
);

  logic [1:0] idx;
  logic [1:0] idx_next;
  logic [1:0] last_idx;
  logic [7:0] cur_byte;
  logic       load;
  logic       out_valid_next;

  always_comb begin
    unique case (job.kind)
      sjk_pkg::JOB_SINGLE:     last_idx = 2'd0;
      sjk_pkg::JOB_TRIPLE:     last_idx = 2'd2;
      sjk_pkg::JOB_TRIPLE_NUL: last_idx = 2'd3;
      default:                 last_idx = 2'd0;
    endcase
  end

  always_comb begin
    if (job.kind == sjk_pkg::JOB_SINGLE) begin
      cur_byte = job.cp[7:0];
    end else begin
      unique case (idx)
        2'd0:    cur_byte = sjk_pkg::UTF8_LEAD3 | {4'h0, job.cp[15:12]};
        2'd1:    cur_byte = sjk_pkg::UTF8_CONT | {2'b00, job.cp[11:6]};
        2'd2:    cur_byte = sjk_pkg::UTF8_CONT | {2'b00, job.cp[5:0]};
        default: cur_byte = sjk_pkg::NUL_BYTE;
      endcase
    end
  end

  assign load      = job_valid && (!out_valid || out_ready);
  assign job_ready = load && (idx == last_idx);

  always_comb begin
    idx_next       = idx;
    out_valid_next = out_valid && !out_ready;
    if (load) begin
      idx_next       = job_ready ? 2'd0 : idx + 2'd1;
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= cur_byte;
      run_end  <= job_ready;
    end
  end

  a_single_idx: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.kind == sjk_pkg::JOB_SINGLE) |-> idx == 2'd0)
    else $error("single-byte item past its first byte");

  a_triple_idx: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.kind == sjk_pkg::JOB_TRIPLE) |-> idx != 2'd3)
    else $error("three-byte item past its last byte");

  a_pop_on_end: assert property (@(posedge clk) disable iff (rst)
    job_ready |=> (out_valid && run_end && idx == 2'd0))
    else $error("item retired without end mark");

endmodule

/* rtl/sjis_kana_to_utf8_stream.sv */
`timescale 1ns / 1ps
// shift-jis (ascii and kana subset) to utf-8 byte stream
// in_ch: one shift-jis byte per item, zero ends a string
// out_ch: one utf-8 byte per item, run_end marks the last byte of an input
// ascii gives one byte, half-width kana and kana pairs give three bytes,
// a lead byte gives nothing until its trail arrives
// a lead byte followed by zero gives the three replacement bytes and a nul
// the input item is registered in the job queue, then in the output register
// the back end gives one output byte per cycle while out_ch is ready and a
// job waits; its byte counter steps through the three bytes of a kana item
// a small job queue sits between the classifier and the byte serializer,
// so input keeps flowing while the output register holds a byte
// when out_ch stalls the output byte holds and the queue fills; in_ch drops
// ready once the queue is full
// reset clears the pending lead byte, the queue and the output valid flag
module sjis_kana_to_utf8_stream #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  sjk_in_if.sink    in_ch,
  sjk_out_if.source out_ch
);

  logic          push_valid;
  logic          push_ready;
  sjk_pkg::job_t push_job;
  logic          job_valid;
  logic          job_ready;
  sjk_pkg::job_t job;

  sjk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  sjk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_job    (job)
  );

  sjk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .run_end   (out_ch.run_end)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sjk_in_if  in_ch ();
  sjk_out_if out_ch ();

  sjis_kana_to_utf8_stream dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  logic [7:0] sjis_q [$];
  utf8_byte_t utf8_due [$];

  logic       lead_held = 1'b0;
  logic [7:0] lead_byte = 8'h00;

  int gap_pct   = 0;
  int stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_seen;
  int hold_left;

  int errors      = 0;
  int bytes_in    = 0;
  int bytes_out   = 0;
  int nul_out     = 0;
  int quiet_count = 0;

  utf8_byte_t want;

  // expected utf-8 bytes for one accepted shift-jis byte
  function automatic void transcode_byte(input logic [7:0] b);
    logic [7:0]  seq [4];
    int          cnt;
    logic [15:0] cp;
    logic        use_cp;
    logic        add_nul;
    cnt     = 0;
    use_cp  = 1'b0;
    add_nul = 1'b0;
    cp      = sjk_pkg::CP_REPLACEMENT;
    if (lead_held) begin
      use_cp = 1'b1;
      if (b == sjk_pkg::NUL_BYTE) begin
        add_nul = 1'b1;
      end else if (lead_byte == sjk_pkg::HIRA_LEAD && b >= sjk_pkg::HIRA_LO &&
                   b <= sjk_pkg::HIRA_HI) begin
        cp = sjk_pkg::CP_HIRAGANA + 16'(b - sjk_pkg::HIRA_LO);
      end else if (lead_byte == sjk_pkg::KATA_LEAD && b >= sjk_pkg::KATA_LO &&
                   b <= sjk_pkg::KATA_HI && b != sjk_pkg::KATA_GAP) begin
        cp = sjk_pkg::CP_KATAKANA + 16'(b - sjk_pkg::KATA_LO) -
             ((b >= sjk_pkg::HIGH_BIT) ? 16'd1 : 16'd0);
      end
      lead_held = 1'b0;
      lead_byte = 8'h00;
    end else if (b < sjk_pkg::HIGH_BIT) begin
      seq[0] = b;
      cnt    = 1;
    end else if (b >= sjk_pkg::HALF_KANA_LO && b <= sjk_pkg::HALF_KANA_HI) begin
      use_cp = 1'b1;
      cp     = sjk_pkg::CP_HALF_KANA + 16'(b - sjk_pkg::HALF_KANA_LO);
    end else begin
      lead_held = 1'b1;
      lead_byte = b;
    end
    if (use_cp) begin
      // every code point reached here is above u+07ff
      seq[0] = sjk_pkg::UTF8_LEAD3 | 8'(cp >> 12);
      seq[1] = sjk_pkg::UTF8_CONT | 8'((cp >> 6) & 16'h003F);
      seq[2] = sjk_pkg::UTF8_CONT | 8'(cp & 16'h003F);
      cnt    = 3;
    end
    if (add_nul) begin
      seq[3] = sjk_pkg::NUL_BYTE;
      cnt    = 4;
    end
    for (int i = 0; i < cnt; i++) begin
      utf8_due.push_back('{data: seq[i], last: (i == cnt - 1)});
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'h00;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (sjis_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= sjis_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        transcode_byte(in_ch.in_byte);
        bytes_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        bytes_out++;
        if (out_ch.out_byte == sjk_pkg::NUL_BYTE) nul_out++;
        if (utf8_due.size() == 0) begin
          $display("%0t: unexpected item, got byte %h run_end %b",
                   $time, out_ch.out_byte, out_ch.run_end);
          errors++;
        end else begin
          want = utf8_due.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, want.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.run_end !== want.last) begin
            $display("%0t: run_end mismatch, expected %b, actual %b",
                     $time, want.last, out_ch.run_end);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("sjis_kana_to_utf8_stream test failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic logic [7:0] any_lead();
    int r;
    r = $urandom_range(64);
    return (r < 33) ? 8'(8'h80 + r) : 8'(8'hE0 + (r - 33));
  endfunction

  task automatic add_random(input int n);
    int k;
    int r;
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        sjis_q.push_back(sjk_pkg::NUL_BYTE);
        k += 1;
      end else if (r < 30) begin
        sjis_q.push_back(8'($urandom_range(8'h7F, 8'h01)));
        k += 1;
      end else if (r < 45) begin
        sjis_q.push_back(8'($urandom_range(sjk_pkg::HALF_KANA_HI, sjk_pkg::HALF_KANA_LO)));
        k += 1;
      end else if (r < 60) begin
        sjis_q.push_back(sjk_pkg::HIRA_LEAD);
        sjis_q.push_back(8'($urandom_range(sjk_pkg::HIRA_HI, sjk_pkg::HIRA_LO)));
        k += 2;
      end else if (r < 75) begin
        sjis_q.push_back(sjk_pkg::KATA_LEAD);
        sjis_q.push_back(8'($urandom_range(sjk_pkg::KATA_HI, sjk_pkg::KATA_LO)));
        k += 2;
      end else if (r < 85) begin
        sjis_q.push_back(any_lead());
        sjis_q.push_back(8'($urandom_range(255)));
        k += 2;
      end else if (r < 90) begin
        sjis_q.push_back(any_lead());
        sjis_q.push_back(sjk_pkg::NUL_BYTE);
        k += 2;
      end else begin
        sjis_q.push_back(8'($urandom_range(255)));
        k += 1;
      end
    end
  endtask

  task automatic drain();
    while (sjis_q.size() != 0 || in_ch.valid || utf8_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(input int gap, input int stall, input int n);
    @(negedge clk);
    gap_pct   = gap;
    stall_pct = stall;
    add_random(n);
    drain();
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: single bytes, kana ranges, gap, lead with terminator, odd pairs
    sjis_q = '{8'h00, 8'h01, 8'h7F, 8'hA1, 8'hDF,
               8'h82, 8'h9F, 8'h82, 8'hF1, 8'h83, 8'h40, 8'h83, 8'h7F,
               8'h83, 8'h80, 8'h83, 8'h96, 8'h82, 8'h00, 8'hFF, 8'h41,
               8'h80, 8'hFF, 8'hE0, 8'hA0};
    drain();

    run_phase(0, 0, 110);
    run_phase(47, 0, 100);
    run_phase(0, 47, 100);
    run_phase(16, 16, 100);

    // long receiver hold while the sender keeps offering
    @(negedge clk);
    gap_pct   = 0;
    stall_pct = 0;
    add_random(40);
    hold_req = ~hold_req;
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("run covered %0d shift-jis bytes in, %0d utf-8 bytes out, %0d nul terminators,",
             bytes_in, bytes_out, nul_out);
    $display("across idle, stall and long back-pressure phases with %0d errors", errors);
    if (errors == 0 && utf8_due.size() == 0) begin
      $display("sjis_kana_to_utf8_stream test passed");
    end else begin
      $display("sjis_kana_to_utf8_stream test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sjk_pkg.sv
rtl/sjk_in_if.sv
rtl/sjk_out_if.sv
rtl/sjk_front.sv
rtl/sjk_queue.sv
rtl/sjk_back.sv
rtl/sjis_kana_to_utf8_stream.sv
verif/tb_top.sv
